// ===== rtl/uartrx_pkg.sv =====
// Package: shared codes and constants for the timed UART receiver.
package uartrx_pkg;

  localparam int unsigned DataBits = 8;
  localparam int unsigned PeriodW  = 12;
  localparam int unsigned CountW   = 16;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_ARM  = 1'b1
  } opcode_e;

  typedef enum logic {
    ST_BYTE    = 1'b0,
    ST_TIMEOUT = 1'b1
  } status_e;

  typedef enum logic {
    REG_BIT_PERIOD    = 1'b0,
    REG_TIMEOUT_TICKS = 1'b1
  } cfg_reg_e;

  localparam logic [PeriodW-1:0] BitPeriodReset    = 12'd104;
  localparam logic [CountW-1:0]  TimeoutTicksReset = 16'd1000;

endpackage

// ===== rtl/uart_receive_with_timeout.sv =====
// Top level: armed 8N1 UART receiver with start-bit timeout.
//
//  channel | handshake               | payload
//  --------+-------------------------+-------------------------------
//  in      | in_valid_i / in_stall_o | opcode_i, rx_level_i
//  out     | out_valid_o/out_stall_i | received_byte_o, status_o
//  cfg     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// Each beat is handled in the cycle it is accepted: one item per clock while in_stall_o is low.
// State updates at the accept edge; a result lands in the output register.
// in_stall_o is high only while a result waits and out_stall_i is high.
// rst_ni clears phase, counters, registers to their reset values.
module uart_receive_with_timeout (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               opcode_i,
  input  logic                               rx_level_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [7:0]                         received_byte_o,
  output logic                               status_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic                               cfg_index_i,
  input  logic [uartrx_pkg::CfgDataW-1:0]    cfg_data_i
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HUNT = 2'd1,
    PH_RECV = 2'd2,
    PH_TAIL = 2'd3
  } phase_e;

  localparam int unsigned PW = uartrx_pkg::PeriodW;
  localparam int unsigned CW = uartrx_pkg::CountW;
  localparam int unsigned DB = uartrx_pkg::DataBits;

  phase_e                 phase_q, phase_d;
  logic [CW-1:0]          count_q, count_d;
  logic [2:0]             bit_idx_q, bit_idx_d;
  logic [DB-1:0]          shift_q, shift_d;
  logic [PW-1:0]          bit_period_q;
  logic [CW-1:0]          timeout_q;
  logic                   out_valid_q;
  logic [DB-1:0]          out_byte_q;
  logic                   out_status_q;

  logic                   in_accept;
  logic                   emit;
  logic                   emit_status;
  logic [DB-1:0]          emit_byte;
  logic [PW-1:0]          period;
  logic [CW-1:0]          start_load;
  logic [CW-1:0]          count_inc;
  logic [CW-1:0]          count_dec;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_accept   = in_valid_i & ~in_stall_o;

  assign period     = (bit_period_q == '0) ? PW'(1) : bit_period_q;
  assign start_load = CW'(1) + CW'(period) + CW'(period >> 1);
  assign count_inc  = count_q + CW'(1);
  assign count_dec  = (count_q != '0) ? count_q - CW'(1) : '0;

  always_comb begin
    phase_d     = phase_q;
    count_d     = count_q;
    bit_idx_d   = bit_idx_q;
    shift_d     = shift_q;
    emit        = 1'b0;
    emit_status = uartrx_pkg::ST_BYTE;
    emit_byte   = '0;
    if (opcode_i == uartrx_pkg::OP_ARM) begin
      if (phase_q == PH_IDLE) begin
        if (timeout_q == '0) begin
          emit        = 1'b1;
          emit_status = uartrx_pkg::ST_TIMEOUT;
        end else begin
          phase_d = PH_HUNT;
          count_d = '0;
        end
      end
    end else begin
      case (phase_q)
        PH_HUNT: begin
          if (!rx_level_i) begin
            count_d   = start_load;
            bit_idx_d = '0;
            shift_d   = '0;
            phase_d   = PH_RECV;
          end else if (count_inc >= timeout_q) begin
            count_d     = '0;
            phase_d     = PH_IDLE;
            emit        = 1'b1;
            emit_status = uartrx_pkg::ST_TIMEOUT;
          end else begin
            count_d = count_inc;
          end
        end
        PH_RECV: begin
          count_d = count_dec;
          if (count_dec == '0) begin
            shift_d = shift_q | (DB'(rx_level_i) << bit_idx_q);
            count_d = CW'(period);
            if (bit_idx_q == 3'(DB - 1)) begin
              bit_idx_d = '0;
              phase_d   = PH_TAIL;
              emit      = 1'b1;
              emit_byte = shift_d;
            end else begin
              bit_idx_d = bit_idx_q + 3'd1;
            end
          end
        end
        PH_TAIL: begin
          count_d = count_dec;
          if (count_dec == '0) begin
            phase_d = PH_IDLE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      count_q      <= '0;
      bit_idx_q    <= '0;
      shift_q      <= '0;
      bit_period_q <= uartrx_pkg::BitPeriodReset;
      timeout_q    <= uartrx_pkg::TimeoutTicksReset;
      out_valid_q  <= 1'b0;
      out_byte_q   <= '0;
      out_status_q <= uartrx_pkg::ST_BYTE;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == uartrx_pkg::REG_BIT_PERIOD) begin
          bit_period_q <= cfg_data_i[PW-1:0];
        end else begin
          timeout_q <= cfg_data_i[CW-1:0];
        end
      end
      if (in_accept) begin
        phase_q   <= phase_d;
        count_q   <= count_d;
        bit_idx_q <= bit_idx_d;
        shift_q   <= shift_d;
      end
      if (in_accept && emit) begin
        out_valid_q  <= 1'b1;
        out_byte_q   <= emit_byte;
        out_status_q <= emit_status;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign received_byte_o = out_byte_q;
  assign status_o        = out_status_q;

  a_byte_enters_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && emit && emit_status == uartrx_pkg::ST_BYTE) |=> phase_q == PH_TAIL)
    else $error("byte result without entering tail");

  a_timeout_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && emit && emit_status == uartrx_pkg::ST_TIMEOUT) |=> phase_q == PH_IDLE)
    else $error("timeout result without returning to idle");

  a_recv_count_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_RECV) |-> count_q != '0)
    else $error("sample counter reached zero while receiving");

  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q)
    else $error("input stalled with empty output register");

endmodule
